### rtl/skht_pkg.sv
// Shared types and constants of the string key hash table.
package skht_pkg;

	localparam int TableDepth = 64;
	localparam int MaxKeyLen = 16;
	localparam int ValueWidth = 32;
	localparam int SlotW = $clog2(TableDepth);
	localparam int CharW = $clog2(MaxKeyLen);
	localparam int LenW = $clog2(MaxKeyLen + 1);
	localparam int SizeW = 7;
	localparam logic [31:0] HashStart = 32'd5381;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_FULL      = 2'd1,
		ST_FOUND     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// One finished key handed from the front to the back.
	typedef struct packed {
		logic                  lookup;
		logic [31:0]           hash;
		logic [LenW-1:0]       len;
		logic [ValueWidth-1:0] value;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_HOME, BK_PROBE, BK_CMP, BK_COPY, BK_DONE
	} back_state_t;

endpackage

### rtl/skht_front.sv
// Front part: folds characters into the djb2 hash and collects the key.
module skht_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  action,
	input  logic [7:0]            key_char,
	input  logic                  key_last,
	input  logic [31:0]           insert_value,
	// Pending key buffer read port for the back part.
	input  logic [skht_pkg::CharW-1:0] key_rd_idx,
	output logic [7:0]            key_rd_char,
	output logic                  job_valid,
	input  logic                  job_ready,
	output skht_pkg::job_t        job
);
	import skht_pkg::*;

	logic [31:0]     hash_q;
	logic [LenW-1:0] len_q;
	logic [7:0]      key_q [MaxKeyLen];
	logic            job_valid_q;
	job_t            job_q;
	logic            acc;
	logic [31:0]     hash_nx;

	// The key buffer is single; hold input while a finished key waits.
	assign in_ready = !job_valid_q;
	assign acc = in_valid && in_ready;
	assign hash_nx = (hash_q << 5) + hash_q + {24'd0, key_char};
	assign job_valid = job_valid_q;
	assign job = job_q;
	assign key_rd_char = key_q[key_rd_idx];

	// Hash, length and job handoff.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HashStart;
			len_q <= '0;
			job_valid_q <= 1'b0;
		end else begin
			if (job_valid_q && job_ready)
				job_valid_q <= 1'b0;
			if (acc) begin
				if (key_last) begin
					hash_q <= HashStart;
					len_q <= '0;
					job_valid_q <= 1'b1;
				end else begin
					hash_q <= hash_nx;
					if (len_q < LenW'(MaxKeyLen))
						len_q <= len_q + 1'b1;
				end
			end
		end
	end

	// Key characters and job payload.
	always_ff @(posedge clk) begin
		if (acc && len_q < LenW'(MaxKeyLen))
			key_q[len_q[CharW-1:0]] <= key_char;
		if (acc && key_last) begin
			job_q.lookup <= action;
			job_q.hash <= hash_nx;
			job_q.len <= (len_q < LenW'(MaxKeyLen)) ? len_q + 1'b1 : len_q;
			job_q.value <= insert_value[ValueWidth-1:0];
		end
	end

endmodule

### rtl/skht_back.sv
// Back part: probes the table, compares or stores keys, returns results.
module skht_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [6:0]            table_size,
	input  logic                  job_valid,
	output logic                  job_ready,
	input  skht_pkg::job_t        job,
	output logic [skht_pkg::CharW-1:0] key_rd_idx,
	input  logic [7:0]            key_rd_char,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [39:0]           out_data
);
	import skht_pkg::*;

	localparam int KeyMemW = SlotW + CharW;

	back_state_t st_q, st_nx;
	logic [TableDepth-1:0] occ_q;
	logic [7:0]            kmem [TableDepth*MaxKeyLen];
	logic [LenW-1:0]       lmem [TableDepth];
	logic [ValueWidth-1:0] vmem [TableDepth];
	logic [7:0]            kmem_rd_q;
	logic [LenW-1:0]       len_rd_q;
	logic [ValueWidth-1:0] val_rd_q;
	job_t                  job_q;
	logic [31:0]           rem_q;
	logic [SizeW-1:0]      size_q;
	logic [SlotW-1:0]      slot_q;
	logic [SizeW-1:0]      cnt_q;
	logic [LenW-1:0]       ci_q;
	logic                  cmp_rd_q;
	logic                  out_valid_q;
	logic [1:0]            status_q;
	logic [31:0]           fval_q;
	logic [SlotW-1:0]      sidx_q;
	logic [39:0]           out_q;
	logic [4:0]            bit_q;
	logic [SizeW-1:0]      size_eff;
	logic [SlotW-1:0]      slot_inc;
	logic [32:0]           rem_tr;
	logic [KeyMemW-1:0]    kaddr;

	assign size_eff = (table_size < 7'd2) ? 7'd2 :
		(table_size > SizeW'(TableDepth)) ? SizeW'(TableDepth) : table_size;
	assign slot_inc = (SizeW'(slot_q) + 1'b1 == size_q) ? '0 : slot_q + 1'b1;
	assign rem_tr = {rem_q, job_q.hash[bit_q]};
	assign kaddr = {slot_q, ci_q[CharW-1:0]};
	assign key_rd_idx = ci_q[CharW-1:0];
	// The job is released once its result moves to the output register, so the
	// front keeps the key characters unchanged while they are compared or copied.
	assign job_ready = (st_q == BK_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	// Result fields, lowest first: status, found_value, slot_index.
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= BK_IDLE;
		else st_q <= st_nx;
	end

	// Sequencer: serial modulo, probe loop, key compare and copy.
	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			BK_IDLE: if (job_valid) st_nx = BK_HOME;
			BK_HOME: if (bit_q == 5'd0) st_nx = BK_PROBE;
			BK_PROBE: begin
				if (cnt_q == size_q) st_nx = BK_DONE;
				else if (!job_q.lookup && !occ_q[slot_q]) st_nx = BK_COPY;
				else if (job_q.lookup && occ_q[slot_q]) st_nx = BK_CMP;
			end
			BK_CMP: if (cmp_rd_q && (len_rd_q != job_q.len || ci_q == job_q.len ||
				kmem_rd_q != key_rd_char)) st_nx = (len_rd_q == job_q.len &&
				ci_q == job_q.len) ? BK_DONE : BK_PROBE;
			BK_COPY: if (ci_q + 1'b1 >= job_q.len) st_nx = BK_DONE;
			BK_DONE: if (!out_valid_q || out_ready) st_nx = BK_IDLE;
			default: st_nx = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (st_q == BK_DONE && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (st_q == BK_PROBE && cnt_q != size_q && !job_q.lookup && !occ_q[slot_q])
				occ_q[slot_q] <= 1'b1;
		end
	end

	// Datapath registers and table memories.
	always_ff @(posedge clk) begin
		kmem_rd_q <= kmem[kaddr];
		len_rd_q <= lmem[slot_q];
		val_rd_q <= vmem[slot_q];
		unique case (st_q)
			BK_IDLE: begin
				job_q <= job;
				size_q <= size_eff;
				rem_q <= '0;
				bit_q <= 5'd31;
				cnt_q <= '0;
				ci_q <= '0;
				cmp_rd_q <= 1'b0;
				status_q <= job.lookup ? ST_NOT_FOUND : ST_FULL;
				fval_q <= '0;
				sidx_q <= '0;
			end
			BK_HOME: begin
				// One restoring division step per cycle.
				if (rem_tr >= {26'd0, size_q}) begin
					rem_q <= 32'(rem_tr - {26'd0, size_q});
					if (bit_q == 5'd0) slot_q <= SlotW'(rem_tr - {26'd0, size_q});
				end else begin
					rem_q <= rem_tr[31:0];
					if (bit_q == 5'd0) slot_q <= rem_tr[SlotW-1:0];
				end
				bit_q <= bit_q - 1'b1;
			end
			BK_PROBE: begin
				ci_q <= '0;
				cmp_rd_q <= 1'b0;
				if (cnt_q != size_q) begin
					if (!job_q.lookup && !occ_q[slot_q]) begin
						lmem[slot_q] <= job_q.len;
						vmem[slot_q] <= job_q.value;
						status_q <= ST_INSERTED;
						sidx_q <= slot_q;
					end else if (!(job_q.lookup && occ_q[slot_q])) begin
						slot_q <= slot_inc;
						cnt_q <= cnt_q + 1'b1;
					end
				end
			end
			BK_CMP: begin
				// Read data is registered and arrives in the cycle after the address.
				if (!cmp_rd_q) begin
					cmp_rd_q <= 1'b1;
				end else begin
					if (len_rd_q == job_q.len && ci_q == job_q.len) begin
						status_q <= ST_FOUND;
						fval_q <= 32'(val_rd_q);
						sidx_q <= slot_q;
					end else if (len_rd_q != job_q.len || kmem_rd_q != key_rd_char) begin
						slot_q <= slot_inc;
						cnt_q <= cnt_q + 1'b1;
					end else begin
						ci_q <= ci_q + 1'b1;
						cmp_rd_q <= 1'b0;
					end
				end
			end
			BK_COPY: begin
				kmem[kaddr] <= key_rd_char;
				ci_q <= ci_q + 1'b1;
			end
			BK_DONE: begin
				// The result moves to the output register as the last one leaves.
				if (!out_valid_q || out_ready)
					out_q <= {sidx_q, fval_q, status_q};
			end
			default: ;
		endcase
	end

endmodule

### rtl/string_key_hash_table.sv
// Top level of the string key hash table.
//  channel  | dir | handshake            | payload
//  s_axis   | in  | tvalid/tready        | tdata, tuser, tlast
//  m_axis   | out | tvalid/tready        | tdata
//  cfg      | in  | cfg_valid/cfg_ready  | cfg_data (table_size)
// Characters are taken one per cycle unless a finished key waits; a key ends with tlast.
// The back part then finds the home slot by bit-serial modulo, steps through the
// probe slots, and compares stored keys character by character.
// Reset clears the occupancy bits at once; no clearing pass is needed.
// New characters are held off until the result of the previous key has moved
// to the output register; a stalled result keeps the back part in its last state.
module string_key_hash_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // key_char[7:0], insert_value[39:8]
	input  logic        s_axis_tuser,  // action
	input  logic        s_axis_tlast,  // key_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // status[1:0], found_value[33:2], slot_index[39:34]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data
);
	import skht_pkg::*;

	logic [6:0]       size_q;
	logic             job_valid, job_ready;
	job_t             job;
	logic [CharW-1:0] rd_idx;
	logic [7:0]       rd_char;

	assign cfg_ready = 1'b1;

	// Table size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) size_q <= 7'd64;
		else if (cfg_valid) size_q <= cfg_data;
	end

	skht_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.action(s_axis_tuser), .key_char(s_axis_tdata[7:0]),
		.key_last(s_axis_tlast), .insert_value(s_axis_tdata[39:8]),
		.key_rd_idx(rd_idx), .key_rd_char(rd_char),
		.job_valid, .job_ready, .job
	);

	skht_back u_back (
		.clk, .arst_n, .table_size(size_q),
		.job_valid, .job_ready, .job,
		.key_rd_idx(rd_idx), .key_rd_char(rd_char),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
	);

endmodule

### rtl/skht_checker.sv
// Port-level checks of the string key hash table, bound to the top level.
module skht_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);
	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");
	// A stalled result stays valid.
	a_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");
	// Misses and full report zero value and slot.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[1:0] == 2'd1 || m_axis_tdata[1:0] == 2'd3)
		|-> m_axis_tdata[39:2] == '0)
		else $error("nonzero fields on miss");
	// Insert reports zero value.
	a_ins: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] == 2'd0 |-> m_axis_tdata[33:2] == '0)
		else $error("value on insert");
endmodule

bind string_key_hash_table skht_port_checks u_skht_port_checks (.*);

### test/skht_checker.sv
// Checker that predicts and compares the results of the string key hash table.
`timescale 1ns / 1ps

module skht_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [6:0]  cfg_data,
	output int          error_count,
	output int          results_owed
);
	import skht_pkg::*;

	typedef struct {
		status_t                status;
		logic [ValueWidth-1:0]  value;
		logic [SlotW-1:0]       slot;
	} table_answer_t;

	// Shadow copy of the table and of the key being collected.
	logic [SizeW-1:0]      size_reg;
	logic                  occupied [TableDepth];
	logic [7:0]            stored_key [TableDepth][MaxKeyLen];
	int                    stored_len [TableDepth];
	logic [ValueWidth-1:0] stored_value [TableDepth];
	logic [31:0]           key_hash;
	logic [7:0]            key_buf [MaxKeyLen];
	int                    key_len;
	table_answer_t         answers_owed [$];

	assign results_owed = answers_owed.size();

	task automatic report(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		error_count++;
	endtask

	function automatic bit same_key(input int slot);
		if (stored_len[slot] != key_len)
			return 0;
		for (int i = 0; i < key_len; i++)
			if (stored_key[slot][i] != key_buf[i])
				return 0;
		return 1;
	endfunction

	// Fold one character in; on the last one run the insert or the lookup.
	task automatic take_char(input logic lookup, input logic [7:0] ch, input logic last,
			input logic [31:0] val);
		int span;
		int slot;
		table_answer_t ans;
		key_hash = key_hash * 33 + ch;
		if (key_len < MaxKeyLen) begin
			key_buf[key_len] = ch;
			key_len++;
		end
		if (!last)
			return;
		span = size_reg < 2 ? 2 : (size_reg > TableDepth ? TableDepth : size_reg);
		slot = key_hash % span;
		ans.value = '0;
		ans.slot = '0;
		ans.status = lookup ? ST_NOT_FOUND : ST_FULL;
		for (int n = 0; n < span; n++) begin
			if (!lookup && !occupied[slot]) begin
				occupied[slot] = 1'b1;
				for (int i = 0; i < key_len; i++)
					stored_key[slot][i] = key_buf[i];
				stored_len[slot] = key_len;
				stored_value[slot] = val;
				ans.status = ST_INSERTED;
				ans.slot = SlotW'(slot);
				break;
			end
			if (lookup && occupied[slot] && same_key(slot)) begin
				ans.status = ST_FOUND;
				ans.value = stored_value[slot];
				ans.slot = SlotW'(slot);
				break;
			end
			slot = (slot + 1) % span;
		end
		answers_owed.push_back(ans);
		key_hash = HashStart;
		key_len = 0;
	endtask

	// Watch every channel at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		table_answer_t want;
		if (!arst_n) begin
			size_reg = 7'd64;
			for (int i = 0; i < TableDepth; i++)
				occupied[i] = 1'b0;
			key_hash = HashStart;
			key_len = 0;
			answers_owed.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				size_reg = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				take_char(s_axis_tuser, s_axis_tdata[7:0], s_axis_tlast, s_axis_tdata[39:8]);
			if (m_axis_tvalid && m_axis_tready) begin
				if (answers_owed.size() == 0) begin
					report("result transaction with nothing expected");
				end else begin
					want = answers_owed.pop_front();
					if (m_axis_tdata[1:0] != want.status)
						report($sformatf("status %0d, expected %0d",
							m_axis_tdata[1:0], want.status));
					if (m_axis_tdata[33:2] != want.value)
						report($sformatf("found_value %h, expected %h",
							m_axis_tdata[33:2], want.value));
					if (m_axis_tdata[39:34] != want.slot)
						report($sformatf("slot_index %0d, expected %0d",
							m_axis_tdata[39:34], want.slot));
				end
			end
		end
	end

	initial error_count = 0;

endmodule

### test/testbench.sv
// Stimulus and verdict for the string key hash table.
`timescale 1ns / 1ps

module testbench;
	import skht_pkg::*;

	localparam int HalfPeriod = 6;
	localparam int CycleLimit = 10000000;
	localparam int PoolSize = 24;
	localparam int PoolLen = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [6:0]  cfg_data = '0;
	int          error_count;
	int          results_owed;
	int          cycles = 0;
	bit          steady = 0;

	logic [7:0]  pool_chars [PoolSize][PoolLen];
	int          pool_len [PoolSize];

	always #HalfPeriod clk = ~clk;

	string_key_hash_table dut (.*);

	skht_checker checker_i (.*);

	// Abort a run that hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Result side: random stalls, except in steady phases.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 3);
			repeat (stall) @(negedge clk) m_axis_tready <= 1'b0;
			@(negedge clk) m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic send_char(input logic lookup, input logic [7:0] ch, input logic last,
			input logic [31:0] val);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		repeat (gap) @(negedge clk) s_axis_tvalid <= 1'b0;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {val, ch};
		s_axis_tuser <= lookup;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Non-final characters carry random action and value bits, which must be ignored.
	task automatic send_pool_key(input int k, input logic lookup, input logic [31:0] val);
		for (int i = 0; i < pool_len[k]; i++)
			send_char(i == pool_len[k] - 1 ? lookup : 1'($urandom),
				pool_chars[k][i], i == pool_len[k] - 1,
				i == pool_len[k] - 1 ? val : $urandom);
	endtask

	// Drain all results, then write the table size with the block idle.
	task automatic set_size(input logic [6:0] size);
		@(negedge clk) s_axis_tvalid <= 1'b0;
		while (results_owed != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= size;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	initial begin
		int k;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed: one-character keys, value extremes, zero and top characters.
		pool_len[0] = 1; pool_chars[0][0] = 8'h41;
		pool_len[1] = 1; pool_chars[1][0] = 8'h00;
		pool_len[2] = 1; pool_chars[2][0] = 8'hff;
		pool_len[3] = 17;
		for (int i = 0; i < 17; i++)
			pool_chars[3][i] = 8'(8'h30 + i);
		send_pool_key(0, 1'b0, 32'h0000_0000);
		send_pool_key(0, 1'b1, '0);
		send_pool_key(1, 1'b1, '0);
		send_pool_key(1, 1'b0, 32'hffff_ffff);
		send_pool_key(2, 1'b0, 32'h8000_0001);
		send_pool_key(1, 1'b1, '0);
		// Long key: the seventeenth character is hashed but not kept.
		send_pool_key(3, 1'b0, 32'h1234_5678);

		// Smallest table: two slots, set directly and by a size of zero.
		set_size(7'd2);
		send_pool_key(0, 1'b0, 32'h5555_aaaa);
		send_pool_key(2, 1'b1, '0);
		send_pool_key(3, 1'b1, '0);
		set_size(7'd0);
		send_pool_key(2, 1'b0, 32'h7);

		// Random key pool: mostly short keys, a few long ones, some past the kept length.
		for (int p = 0; p < PoolSize; p++) begin
			pool_len[p] = ($urandom_range(0, 7) == 0) ? $urandom_range(15, PoolLen)
				: $urandom_range(1, 4);
			for (int i = 0; i < PoolLen; i++)
				pool_chars[p][i] = 8'($urandom);
			if (p % 6 == 0)
				pool_chars[p][0] = 8'h00;
		end

		// Random phases under different table sizes.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_size(7'd127);
				1: set_size(7'd1);
				2: set_size(7'd64);
				3: set_size(7'd5);
				4: set_size(7'd65);
				default: set_size(7'($urandom_range(2, 64)));
			endcase
			steady = (ph % 3 == 2);
			for (int n = 0; n < 45; n++) begin
				k = $urandom_range(0, PoolSize - 1);
				send_pool_key(k, $urandom_range(0, 2) != 0, $urandom);
			end
		end
		steady = 0;

		@(negedge clk) s_axis_tvalid <= 1'b0;
		while (results_owed != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### sim.f
rtl/skht_pkg.sv
rtl/skht_front.sv
rtl/skht_back.sv
rtl/string_key_hash_table.sv
rtl/skht_checker.sv
test/skht_checker.sv
test/testbench.sv
